FILE: hdl/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared constants for the LSD radix sorter
// Field widths, register reset value and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

  localparam int VAL_W         = 31;            // width of one value
  localparam int WORD_W        = 2 * VAL_W;     // stored word: {value, running quotient}
  localparam int RADIX_W       = 9;             // width of the base register
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
  localparam int MIN_RADIX     = 2;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int MAX_RADIX_DEF = 256;

endpackage

`default_nettype wire

FILE: hdl/lsd_radix_sort.sv
// ----------------------------------------------------------------------------
// lsd_radix_sort: LSD radix sorter with counting-sort passes
// Collects words, sorts them by least-significant-digit radix sort in a
// programmable base with a shared divider, then streams them out ascending.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  input     | value, last_item                        | start & !busy
//  result    | sorted_value, last_result               | result_valid, one cycle
//  config    | cfg_data (base)                         | cfg_we, no wait
//
//  Loading takes one word per cycle; busy stays low until the last_item word.
//  Each pass clears the bucket counters, finds the digit of every word with
//  the 31-step divider, forms the prefix sums, scatters the words into the
//  other bank and divides the running maximum by the effective base.
//  Reset is synchronous; the buckets are cleared at the start of every pass,
//  so no clearing sweep follows reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_radix_sort #(
  parameter int MAX_ITEMS = lsd_pkg::MAX_ITEMS_DEF,
  parameter int MAX_RADIX = lsd_pkg::MAX_RADIX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input words
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [lsd_pkg::VAL_W-1:0]    value,
  input  wire logic                         last_item,
  // base register
  input  wire logic                         cfg_we,
  input  wire logic [lsd_pkg::RADIX_W-1:0]  cfg_data,
  // sorted words
  output logic                              result_valid,
  output logic      [lsd_pkg::VAL_W-1:0]    sorted_value,
  output logic                              last_result
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;   // word address
  localparam int CW = $clog2(MAX_ITEMS + 1);                     // word count
  localparam int BW = $clog2(MAX_RADIX + 1);                     // base
  localparam int DW = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;   // digit
  localparam int VW = lsd_pkg::VAL_W;
  localparam int WW = lsd_pkg::WORD_W;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_CNT_RD   = 4'd3;
  localparam logic [3:0] S_CNT_GO   = 4'd4;
  localparam logic [3:0] S_CNT_DIV  = 4'd5;
  localparam logic [3:0] S_CNT_INC  = 4'd6;
  localparam logic [3:0] S_PRE_RD   = 4'd7;
  localparam logic [3:0] S_PRE_WR   = 4'd8;
  localparam logic [3:0] S_SC_RD    = 4'd9;
  localparam logic [3:0] S_SC_CNT   = 4'd10;
  localparam logic [3:0] S_SC_WR    = 4'd11;
  localparam logic [3:0] S_REST_GO  = 4'd12;
  localparam logic [3:0] S_REST_DIV = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;
  localparam logic [3:0] S_FIN      = 4'd15;

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [lsd_pkg::RADIX_W-1:0]  radix_base;
  logic                         cur;          // bank holding the current order
  logic [CW-1:0]                item_count;
  logic [VW-1:0]                max_value;    // also the running rest of the passes
  logic [CW-1:0]                idx;
  logic [DW-1:0]                k;
  logic [CW-1:0]                run;
  logic [WW-1:0]                word;
  logic [DW-1:0]                digit;
  logic                         emit;
  logic                         emit_last;

  logic [BW-1:0]                base_eff;
  logic [DW-1:0]                base_last;
  logic [CW-1:0]                idx_m1;
  logic [CW-1:0]                idx_p1;
  logic [CW-1:0]                pre_sum;
  logic [CW-1:0]                pos;
  logic                         accept;
  logic                         room;

  // memory ports
  logic [1:0]                   bank_we;
  logic [IW-1:0]                bank_waddr;
  logic [WW-1:0]                bank_wdata;
  logic [IW-1:0]                bank_raddr;
  logic [WW-1:0]                bank0_rdata;
  logic [WW-1:0]                bank1_rdata;
  logic [WW-1:0]                bank_rdata;
  logic                         dig_we;
  logic [IW-1:0]                dig_waddr;
  logic [DW-1:0]                dig_wdata;
  logic [IW-1:0]                dig_raddr;
  logic [DW-1:0]                dig_rdata;
  logic                         cnt_we;
  logic [DW-1:0]                cnt_waddr;
  logic [CW-1:0]                cnt_wdata;
  logic [DW-1:0]                cnt_raddr;
  logic [CW-1:0]                cnt_rdata;

  // shared divider
  logic                         div_start;
  logic [VW-1:0]                div_dividend;
  logic [VW-1:0]                div_quo;
  logic [DW-1:0]                div_rem;
  logic                         div_done;

  // base clamped into [2, MAX_RADIX]
  always_comb begin
    if (32'(radix_base) < 32'(lsd_pkg::MIN_RADIX)) begin
      base_eff = BW'(lsd_pkg::MIN_RADIX);
    end else if (32'(radix_base) > 32'(MAX_RADIX)) begin
      base_eff = BW'(MAX_RADIX);
    end else begin
      base_eff = BW'(radix_base);
    end
  end

  assign base_last = DW'(base_eff - BW'(1));
  assign idx_m1    = idx - CW'(1);
  assign idx_p1    = idx + CW'(1);
  assign pre_sum   = run + cnt_rdata;
  assign pos       = cnt_rdata - CW'(1);
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign room      = (item_count < CW'(MAX_ITEMS));
  assign bank_rdata = cur ? bank1_rdata : bank0_rdata;

  // result port: bank read data is registered, and the strobe is registered from the same read state so both line up
  assign result_valid = emit;
  assign last_result  = emit_last;
  assign sorted_value = bank_rdata[WW-1:VW];

  // ---------------------------------------------------------------------------
  // Sequencer datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    bank_we      = 2'b00;
    bank_waddr   = idx[IW-1:0];
    bank_wdata   = word;
    bank_raddr   = idx[IW-1:0];
    dig_we       = 1'b0;
    dig_waddr    = idx[IW-1:0];
    dig_wdata    = div_rem;
    dig_raddr    = idx_m1[IW-1:0];
    cnt_we       = 1'b0;
    cnt_waddr    = k;
    cnt_wdata    = '0;
    cnt_raddr    = k;
    div_start    = 1'b0;
    div_dividend = bank_rdata[VW-1:0];

    case (state)
      S_IDLE: begin
        // a word is stored with its running quotient equal to itself
        if (accept) begin
          if (room) begin
            bank_we[cur] = 1'b1;
            bank_waddr   = item_count[IW-1:0];
            bank_wdata   = {value, value};
          end
          if (last_item) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_next = (max_value == '0) ? S_OUT : S_CLR;
      end
      S_CLR: begin
        cnt_we = 1'b1;
        if (k == base_last) begin
          state_next = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        state_next = S_CNT_GO;
      end
      S_CNT_GO: begin
        div_start  = 1'b1;
        state_next = S_CNT_DIV;
      end
      S_CNT_DIV: begin
        // digit is the remainder; the quotient carries on to the next pass
        if (div_done) begin
          bank_we[cur] = 1'b1;
          bank_wdata   = {word[WW-1:VW], div_quo};
          dig_we       = 1'b1;
          cnt_raddr    = div_rem;
          state_next   = S_CNT_INC;
        end
      end
      S_CNT_INC: begin
        cnt_we     = 1'b1;
        cnt_waddr  = digit;
        cnt_wdata  = cnt_rdata + CW'(1);
        state_next = (idx_p1 == item_count) ? S_PRE_RD : S_CNT_RD;
      end
      S_PRE_RD: begin
        state_next = S_PRE_WR;
      end
      S_PRE_WR: begin
        cnt_we     = 1'b1;
        cnt_wdata  = pre_sum;
        state_next = (k == base_last) ? S_SC_RD : S_PRE_RD;
      end
      S_SC_RD: begin
        bank_raddr = idx_m1[IW-1:0];
        state_next = S_SC_CNT;
      end
      S_SC_CNT: begin
        cnt_raddr  = dig_rdata;
        state_next = S_SC_WR;
      end
      S_SC_WR: begin
        // stable scatter from the top word down into the other bank
        cnt_we        = 1'b1;
        cnt_waddr     = digit;
        cnt_wdata     = pos;
        bank_we[!cur] = 1'b1;
        bank_waddr    = pos[IW-1:0];
        state_next    = (idx == CW'(1)) ? S_REST_GO : S_SC_RD;
      end
      S_REST_GO: begin
        div_start    = 1'b1;
        div_dividend = max_value;
        state_next   = S_REST_DIV;
      end
      S_REST_DIV: begin
        if (div_done) begin
          state_next = (div_quo == '0) ? S_OUT : S_CLR;
        end
      end
      S_OUT: begin
        if (idx_p1 == item_count) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      radix_base <= lsd_pkg::RADIX_RESET;
      cur        <= 1'b0;
      item_count <= '0;
      max_value  <= '0;
      emit       <= 1'b0;
      emit_last  <= 1'b0;
    end else begin
      state <= state_next;
      emit  <= 1'b0;
      if (cfg_we) begin
        radix_base <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept && room) begin
            item_count <= item_count + CW'(1);
            if (value > max_value) begin
              max_value <= value;
            end
          end
        end
        S_SC_WR: begin
          if (idx == CW'(1)) begin
            cur <= !cur;
          end
        end
        S_REST_DIV: begin
          if (div_done) begin
            max_value <= div_quo;
          end
        end
        S_OUT: begin
          emit      <= 1'b1;
          emit_last <= (idx_p1 == item_count);
        end
        S_FIN: begin
          item_count <= '0;
          max_value  <= '0;
          emit_last  <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Counters and working registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_CHECK: begin
        k   <= '0;
        idx <= '0;
      end
      S_CLR: begin
        k <= (k == base_last) ? '0 : k + DW'(1);
        idx <= '0;
      end
      S_CNT_GO: begin
        word <= bank_rdata;
      end
      S_CNT_DIV: begin
        if (div_done) begin
          digit <= div_rem;
        end
      end
      S_CNT_INC: begin
        idx <= idx_p1;
        k   <= '0;
        run <= '0;
      end
      S_PRE_WR: begin
        run <= pre_sum;
        k   <= k + DW'(1);
        idx <= item_count;
      end
      S_SC_CNT: begin
        digit <= dig_rdata;
        word  <= bank_rdata;
      end
      S_SC_WR: begin
        idx <= idx_m1;
      end
      S_REST_DIV: begin
        k   <= '0;
        idx <= '0;
      end
      S_OUT: begin
        idx <= idx_p1;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Storage: two word banks (ping-pong per pass), digit store, bucket counters
  // ---------------------------------------------------------------------------
  lsd_ram #(.WIDTH(WW), .DEPTH(MAX_ITEMS)) u_bank0 (
    .clk   (clk),
    .we    (bank_we[0]),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .raddr (bank_raddr),
    .rdata (bank0_rdata)
  );

  lsd_ram #(.WIDTH(WW), .DEPTH(MAX_ITEMS)) u_bank1 (
    .clk   (clk),
    .we    (bank_we[1]),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .raddr (bank_raddr),
    .rdata (bank1_rdata)
  );

  lsd_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_digits (
    .clk   (clk),
    .we    (dig_we),
    .waddr (dig_waddr),
    .wdata (dig_wdata),
    .raddr (dig_raddr),
    .rdata (dig_rdata)
  );

  lsd_ram #(.WIDTH(CW), .DEPTH(MAX_RADIX)) u_buckets (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  lsd_div #(.MAX_RADIX(MAX_RADIX)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (base_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

endmodule

`default_nettype wire

FILE: hdl/lsd_ram.sv
// ----------------------------------------------------------------------------
// lsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/lsd_div.sv
// ----------------------------------------------------------------------------
// lsd_div: shared restoring divider
// Divides a value by the digit base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_div #(
  parameter int MAX_RADIX = lsd_pkg::MAX_RADIX_DEF,
  localparam int BW       = $clog2(MAX_RADIX + 1),
  localparam int DW       = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lsd_pkg::VAL_W-1:0] dividend,
  input  wire logic [BW-1:0]            divisor,
  output logic      [lsd_pkg::VAL_W-1:0] quotient,
  output logic      [DW-1:0]            remainder,
  output logic                          done
);

  localparam int STEP_W = $clog2(lsd_pkg::VAL_W + 1);

  logic              active;
  logic [STEP_W-1:0] cnt;
  logic [BW-1:0]     rem;
  logic [BW-1:0]     rem_next;
  logic [BW:0]       trial;
  logic [BW:0]       diff;
  logic              ge;

  // partial remainder shifted left, next dividend bit brought in
  assign trial    = {rem, quotient[lsd_pkg::VAL_W-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = ge ? diff[BW-1:0] : trial[BW-1:0];

  assign remainder = rem[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= STEP_W'(lsd_pkg::VAL_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (active) begin
      quotient <= {quotient[lsd_pkg::VAL_W-2:0], ge};
      rem      <= rem_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lsd_chk.sv
// ----------------------------------------------------------------------------
// lsd_chk: port-level checks for the LSD radix sorter
// Watches the start/busy handshake and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic last_item,
  input wire logic result_valid,
  input wire logic last_result
);

  // busy stays low after a plain word
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_item |=> !busy)
    else $error("busy after a plain word");

  // the closing word starts the sort
  a_sort_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_item |=> busy)
    else $error("sort did not start on last word");

  // results only come out while the block is busy
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result while idle");

  // last flag only with a strobe, and the stream stops after it
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last_result |-> result_valid)
    else $error("last flag without strobe");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid)
    else $error("result after the last one");

endmodule

bind lsd_radix_sort lsd_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last_item    (last_item),
  .result_valid (result_valid),
  .last_result  (last_result)
);

`default_nettype wire
